// ===== hw/rtl/glu_pkg.sv =====
// shared constants, types and microcode table for the gcd and lcm unit
package glu_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int POS_WIDTH   = DATA_WIDTH - 1;
   localparam int PROD_WIDTH  = 2 * POS_WIDTH;
   localparam int SHIFT_WIDTH = $clog2(POS_WIDTH);
   localparam int CNT_WIDTH   = $clog2(POS_WIDTH + 1);
   localparam int UPC_WIDTH   = 3;

   typedef logic [UPC_WIDTH-1:0] upc_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_BAD = 2'd1,
      ST_OVF = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_BAD   = 3'd0,
      OP_TWOS  = 3'd1,
      OP_GSTEP = 3'd2,
      OP_GFIN  = 3'd3,
      OP_DIV   = 3'd4,
      OP_MSET  = 3'd5,
      OP_MUL   = 3'd6,
      OP_FIN   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CND_ALWAYS    = 3'd0,
      CND_INVALID   = 3'd1,
      CND_BOTH_EVEN = 3'd2,
      CND_BOTH_NZ   = 3'd3,
      CND_CNT_NZ    = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
      logic     last;
   } uword_type;

   localparam upc_type UPC_CHECK = 3'd0;
   localparam upc_type UPC_TWOS  = 3'd1;
   localparam upc_type UPC_GSTEP = 3'd2;
   localparam upc_type UPC_GFIN  = 3'd3;
   localparam upc_type UPC_DIV   = 3'd4;
   localparam upc_type UPC_MSET  = 3'd5;
   localparam upc_type UPC_MUL   = 3'd6;
   localparam upc_type UPC_FIN   = 3'd7;

   // when the condition holds: run op, go to target, finish if last; else fall through
   function automatic uword_type ucode_rom(upc_type pc);
      uword_type w;
      unique case (pc)
         UPC_CHECK: w = '{op: OP_BAD,   cond: CND_INVALID,   target: UPC_CHECK, last: 1'b1};
         UPC_TWOS:  w = '{op: OP_TWOS,  cond: CND_BOTH_EVEN, target: UPC_TWOS,  last: 1'b0};
         UPC_GSTEP: w = '{op: OP_GSTEP, cond: CND_BOTH_NZ,   target: UPC_GSTEP, last: 1'b0};
         UPC_GFIN:  w = '{op: OP_GFIN,  cond: CND_ALWAYS,    target: UPC_DIV,   last: 1'b0};
         UPC_DIV:   w = '{op: OP_DIV,   cond: CND_CNT_NZ,    target: UPC_DIV,   last: 1'b0};
         UPC_MSET:  w = '{op: OP_MSET,  cond: CND_ALWAYS,    target: UPC_MUL,   last: 1'b0};
         UPC_MUL:   w = '{op: OP_MUL,   cond: CND_CNT_NZ,    target: UPC_MUL,   last: 1'b0};
         UPC_FIN:   w = '{op: OP_FIN,   cond: CND_ALWAYS,    target: UPC_CHECK, last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/gcd_lcm_unit_top.sv =====
// gcd and lcm unit: microcoded binary gcd, shift-subtract divide, shift-add multiply
//
//   channel   handshake             payload
//   request   start / busy          req_a_value, req_b_value
//   response  rsp_valid (strobe)    rsp_gcd_result, rsp_lcm_result, rsp_status
//
// a word is taken when start is high and busy is low; busy falls with the
// response strobe, so one word is in flight at a time.
// an invalid word is answered from the check step; a valid one runs the
// check step, the binary gcd steps, a gcd fixup, the divide steps, a multiply
// setup, the multiply steps and the finish step; the run time is set by the
// one-bit subtract/add loops of the datapath.
// reset clears busy and the strobe.
// the receiver cannot stall: each response is shown for one cycle.
module gcd_lcm_unit_top
   import glu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [DATA_WIDTH-1:0]  req_a_value,
   input  logic [DATA_WIDTH-1:0]  req_b_value,
   output logic                   rsp_valid,
   output logic [POS_WIDTH-1:0]   rsp_gcd_result,
   output logic [POS_WIDTH-1:0]   rsp_lcm_result,
   output logic [1:0]             rsp_status
);

   logic                   busy_ff, busy_in;
   upc_type                pc_ff, pc_in;
   logic [DATA_WIDTH-1:0]  a_ff, a_in;
   logic [DATA_WIDTH-1:0]  b_ff, b_in;
   logic [POS_WIDTH-1:0]   x_ff, x_in;
   logic [POS_WIDTH-1:0]   y_ff, y_in;
   logic [SHIFT_WIDTH-1:0] k_ff, k_in;
   logic [POS_WIDTH-1:0]   g_ff, g_in;
   logic [POS_WIDTH-1:0]   rem_ff, rem_in;
   logic [POS_WIDTH-1:0]   quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [PROD_WIDTH-1:0]  acc_ff, acc_in;
   logic [PROD_WIDTH-1:0]  mcand_ff, mcand_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_WIDTH-1:0]   rsp_gcd_ff, rsp_gcd_in;
   logic [POS_WIDTH-1:0]   rsp_lcm_ff, rsp_lcm_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   uword_type              uw;
   logic                   fire;
   logic                   invalid;
   logic                   x_ge_y;
   logic [POS_WIDTH-1:0]   x_minus_y;
   logic [POS_WIDTH-1:0]   y_minus_x;
   logic [POS_WIDTH:0]     trial;
   logic [POS_WIDTH:0]     trial_diff;
   logic                   trial_ok;
   logic                   ovf;

   assign uw        = ucode_rom(pc_ff);
   assign invalid   = a_ff[DATA_WIDTH-1] || (a_ff == '0) ||
                      b_ff[DATA_WIDTH-1] || (b_ff == '0);
   assign x_ge_y    = x_ff >= y_ff;
   assign x_minus_y = x_ff - y_ff;
   assign y_minus_x = y_ff - x_ff;
   assign trial      = {rem_ff, quo_ff[POS_WIDTH-1]};
   assign trial_diff = trial - {1'b0, g_ff};
   assign trial_ok   = trial >= {1'b0, g_ff};
   assign ovf        = |acc_ff[PROD_WIDTH-1:POS_WIDTH];

   always_comb begin
      fire = 1'b0;
      unique case (uw.cond)
         CND_ALWAYS:    fire = 1'b1;
         CND_INVALID:   fire = invalid;
         CND_BOTH_EVEN: fire = !x_ff[0] && !y_ff[0];
         CND_BOTH_NZ:   fire = (x_ff != '0) && (y_ff != '0);
         CND_CNT_NZ:    fire = cnt_ff != '0;
         default:       fire = 1'b0;
      endcase
   end

   always_comb begin
      busy_in       = busy_ff;
      pc_in         = pc_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      k_in          = k_ff;
      g_in          = g_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      rsp_valid_in  = 1'b0;
      rsp_gcd_in    = rsp_gcd_ff;
      rsp_lcm_in    = rsp_lcm_ff;
      rsp_status_in = rsp_status_ff;

      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = UPC_CHECK;
            a_in    = req_a_value;
            b_in    = req_b_value;
            x_in    = req_a_value[POS_WIDTH-1:0];
            y_in    = req_b_value[POS_WIDTH-1:0];
            k_in    = '0;
         end
      end else if (fire) begin
         pc_in = uw.target;
         if (uw.last) begin
            busy_in = 1'b0;
         end
         unique case (uw.op)
            OP_BAD: begin
               rsp_valid_in  = 1'b1;
               rsp_gcd_in    = '0;
               rsp_lcm_in    = '0;
               rsp_status_in = ST_BAD;
            end
            OP_TWOS: begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + SHIFT_WIDTH'(1);
            end
            OP_GSTEP: begin
               priority if (!x_ff[0]) begin
                  x_in = x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end else if (x_ge_y) begin
                  x_in = x_minus_y >> 1;
               end else begin
                  y_in = y_minus_x >> 1;
               end
            end
            OP_GFIN: begin
               g_in   = (x_ff | y_ff) << k_ff;
               rem_in = '0;
               quo_in = a_ff[POS_WIDTH-1:0];
               cnt_in = CNT_WIDTH'(POS_WIDTH);
            end
            OP_DIV: begin
               rem_in = trial_ok ? trial_diff[POS_WIDTH-1:0] : trial[POS_WIDTH-1:0];
               quo_in = {quo_ff[POS_WIDTH-2:0], trial_ok};
               cnt_in = cnt_ff - CNT_WIDTH'(1);
            end
            OP_MSET: begin
               acc_in   = '0;
               mcand_in = {{POS_WIDTH{1'b0}}, b_ff[POS_WIDTH-1:0]};
               cnt_in   = CNT_WIDTH'(POS_WIDTH);
            end
            OP_MUL: begin
               if (quo_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in = mcand_ff << 1;
               quo_in   = quo_ff >> 1;
               cnt_in   = cnt_ff - CNT_WIDTH'(1);
            end
            OP_FIN: begin
               rsp_valid_in  = 1'b1;
               rsp_gcd_in    = g_ff;
               rsp_lcm_in    = ovf ? {POS_WIDTH{1'b1}} : acc_ff[POS_WIDTH-1:0];
               rsp_status_in = ovf ? ST_OVF : ST_OK;
            end
         endcase
      end else begin
         pc_in = pc_ff + UPC_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= UPC_CHECK;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      k_ff          <= k_in;
      g_ff          <= g_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      rsp_gcd_ff    <= rsp_gcd_in;
      rsp_lcm_ff    <= rsp_lcm_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gcd_result = rsp_gcd_ff;
   assign rsp_lcm_result = rsp_lcm_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== test/gcd_lcm_checker.sv =====
// checker for the gcd and lcm unit: predicts each accepted word and compares the responses
module gcd_lcm_checker
   import glu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_a_value,
   input  logic [DATA_WIDTH-1:0] req_b_value,
   input  logic                  rsp_valid,
   input  logic [POS_WIDTH-1:0]  rsp_gcd_result,
   input  logic [POS_WIDTH-1:0]  rsp_lcm_result,
   input  logic [1:0]            rsp_status,
   output int                    mismatches,
   output int                    pending
);

   localparam logic [POS_WIDTH-1:0] LCM_CEIL = '1;

   typedef struct {
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [POS_WIDTH-1:0]  gcd;
      logic [POS_WIDTH-1:0]  lcm;
      status_type            status;
   } answer_type;

   answer_type answers_due[$];
   int         fail_count = 0;
   int         due_count  = 0;

   assign mismatches = fail_count;
   assign pending    = due_count;

   function automatic answer_type gcd_lcm_of(logic [DATA_WIDTH-1:0] a,
                                             logic [DATA_WIDTH-1:0] b);
      answer_type  ans;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] r;
      logic [63:0] prod;
      ans = '{a: a, b: b, gcd: '0, lcm: '0, status: ST_BAD};
      if (a == '0 || a[DATA_WIDTH-1] || b == '0 || b[DATA_WIDTH-1]) return ans;
      x = 64'(a);
      y = 64'(b);
      // euclid
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      prod = (64'(a) / x) * 64'(b);
      ans.gcd = x[POS_WIDTH-1:0];
      if (prod > 64'(LCM_CEIL)) begin
         ans.lcm    = LCM_CEIL;
         ans.status = ST_OVF;
      end else begin
         ans.lcm    = prod[POS_WIDTH-1:0];
         ans.status = ST_OK;
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               report_mismatch("response with no word outstanding");
            end else begin
               want = answers_due.pop_front();
               if (rsp_gcd_result != want.gcd)
                  report_mismatch($sformatf("gcd_result got %0d want %0d (a=%0d b=%0d)",
                                            rsp_gcd_result, want.gcd,
                                            $signed(want.a), $signed(want.b)));
               if (rsp_lcm_result != want.lcm)
                  report_mismatch($sformatf("lcm_result got %0d want %0d (a=%0d b=%0d)",
                                            rsp_lcm_result, want.lcm,
                                            $signed(want.a), $signed(want.b)));
               if (rsp_status != want.status)
                  report_mismatch($sformatf("status got %0d want %0d (a=%0d b=%0d)",
                                            rsp_status, want.status,
                                            $signed(want.a), $signed(want.b)));
            end
         end
         if (start && !busy) answers_due.push_back(gcd_lcm_of(req_a_value, req_b_value));
      end
      due_count = answers_due.size();
   end

endmodule

// ===== test/gcd_lcm_unit_top_tb.sv =====
// testbench top for the gcd and lcm unit: drives words in bursts and gives the verdict
module gcd_lcm_unit_top_tb;
   import glu_pkg::*;

   localparam int RANDOM_WORDS = 800;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {POS_WIDTH{1'b1}}};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic [DATA_WIDTH-1:0] req_a_value = '0;
   logic [DATA_WIDTH-1:0] req_b_value = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [POS_WIDTH-1:0]  rsp_gcd_result;
   logic [POS_WIDTH-1:0]  rsp_lcm_result;
   logic [1:0]            rsp_status;
   int                    mismatches;
   int                    pending;
   int                    cycle_count = 0;
   int                    burst_left  = 0;

   always #6 clock = ~clock;

   gcd_lcm_unit_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_a_value    (req_a_value),
      .req_b_value    (req_b_value),
      .rsp_valid      (rsp_valid),
      .rsp_gcd_result (rsp_gcd_result),
      .rsp_lcm_result (rsp_lcm_result),
      .rsp_status     (rsp_status)
   );

   gcd_lcm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_a_value    (req_a_value),
      .req_b_value    (req_b_value),
      .rsp_valid      (rsp_valid),
      .rsp_gcd_result (rsp_gcd_result),
      .rsp_lcm_result (rsp_lcm_result),
      .rsp_status     (rsp_status),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** gcd_lcm_unit_top: FAILED **");
         $finish;
      end
   end

   // idle between bursts, then hold the word until it is taken
   task automatic send_word(input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 4);
            2: gap = $urandom_range(5, 40);
            default: gap = $urandom_range(41, 150);
         endcase
         if (gap > 0) begin
            start       <= 1'b0;
            req_a_value <= $urandom;
            req_b_value <= $urandom;
            repeat (gap) @(posedge clock);
         end
      end
      start       <= 1'b1;
      req_a_value <= a;
      req_b_value <= b;
      do @(posedge clock); while (!(start && !busy));
   endtask

   task automatic draw_pair(output logic [DATA_WIDTH-1:0] a, output logic [DATA_WIDTH-1:0] b);
      logic [DATA_WIDTH-1:0] g;
      case ($urandom_range(0, 9))
         0: begin
            a = $urandom;
            b = $urandom;
         end
         1: begin
            a = $urandom_range(0, 1) ? '0 : DATA_WIDTH'($urandom);
            b = $urandom_range(0, 1) ? '0 : DATA_WIDTH'($urandom);
         end
         2, 3: begin
            a = $urandom & POS_MAX;
            b = $urandom & POS_MAX;
         end
         4, 5: begin
            a = $urandom_range(1, 1000);
            b = $urandom_range(1, 1000);
         end
         6, 7: begin
            g = $urandom_range(1, 1 << $urandom_range(0, 20));
            a = g * $urandom_range(1, POS_MAX / g);
            b = g * $urandom_range(1, POS_MAX / g);
         end
         8: begin
            a = DATA_WIDTH'($urandom_range(1, 255)) << $urandom_range(0, 23);
            b = DATA_WIDTH'($urandom_range(1, 255)) << $urandom_range(0, 23);
         end
         default: begin
            // operands near the square root of the ceiling, lcm near saturation
            a = $urandom_range(45341, 47341);
            b = $urandom_range(45341, 47341);
         end
      endcase
   endtask

   initial begin
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // operand not positive
      send_word(0, 5);
      send_word(5, 0);
      send_word(0, 0);
      send_word(32'hFFFF_FFF9, 14);
      send_word(32'h8000_0000, 3);
      send_word(3, 32'hFFFF_FFFF);
      send_word(32'h8000_0000, 32'hFFFF_FFFF);
      // extremes and ordinary cases
      send_word(1, 1);
      send_word(1, POS_MAX);
      send_word(POS_MAX, 1);
      send_word(POS_MAX, POS_MAX);
      send_word(12, 18);
      send_word(96, 64);
      send_word(65536, 32768);
      send_word(32'h4000_0000, 32'h4000_0000);
      send_word(32'h4000_0000, 2);
      send_word(32'h7FFF_FFFE, 32'h3FFF_FFFF);
      send_word(46341, 46340);
      send_word(323, 437);
      send_word(1_000_000_007, 2);
      // lcm saturates
      send_word(46341, 46342);
      send_word(32'h4000_0000, 3);
      send_word(POS_MAX, POS_MAX - 1);
      send_word(1_000_000_007, 3);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         draw_pair(a, b);
         send_word(a, b);
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** gcd_lcm_unit_top: PASSED **");
      else
         $display("** gcd_lcm_unit_top: FAILED **");
      $finish;
   end

endmodule
